### design/keyed_fixed_window_rate_limiter_macros.svh
// Assertion macros used by the checker file.
`ifndef KEYED_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`define KEYED_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define KWFRL_ASSERT_IMPLY(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("kwfrl assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define KWFRL_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("kwfrl assertion failed");

`endif

### design/kwfrl_pkg.sv
// Shared types and constants of the keyed fixed-window rate limiter.
package kwfrl_pkg;

  localparam int DEF_SOURCE_ENTRIES   = 16;
  localparam int DEF_DEST_ENTRIES     = 16;
  localparam int DEF_KEY_WIDTH        = 64;
  localparam int DEF_MAX_SOURCE_BYTES = 255;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 208;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLED        = 3'd0,
    REG_PAY_AMOUNT     = 3'd1,
    REG_SOURCE_WINDOW  = 3'd2,
    REG_SOURCE_LIMIT   = 3'd3,
    REG_DEST_WINDOW    = 3'd4,
    REG_ADDRESS_LIMIT  = 3'd5,
    REG_GLOBAL_WINDOW  = 3'd6,
    REG_GLOBAL_BUDGET  = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_PAID         = 3'd0,
    ST_DISABLED     = 3'd1,
    ST_INVALID      = 3'd2,
    ST_BAD_ADDRESS  = 3'd3,
    ST_RATE_LIMITED = 3'd4,
    ST_FAILED       = 3'd5
  } status_t;

  // Command broadcast to every cell of one table.
  typedef struct packed {
    logic        prune;
    logic        lookup;
    logic        restart;
    logic        incr;
    logic [31:0] now;
    logic [31:0] win;
  } cell_op_t;

  // Priority chain passed from cell to cell.
  typedef struct packed {
    logic hit;
    logic free;
  } chain_t;

  // now >= start and now - start >= win
  function automatic logic expired(input logic [31:0] now, input logic [31:0] start,
                                   input logic [31:0] win);
    return (now >= start) && ((now - start) >= win);
  endfunction

  // now < start or now - start >= win
  function automatic logic stale(input logic [31:0] now, input logic [31:0] start,
                                 input logic [31:0] win);
    return (now < start) || ((now - start) >= win);
  endfunction

endpackage

### design/kwfrl_cell.sv
// One table entry: valid bit, key, window start and count, with chain logic.
module kwfrl_cell import kwfrl_pkg::*; #(
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_op_t             op,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic                 global_hit,
  input  logic                 sel,
  input  chain_t               chain_in,
  output chain_t               chain_out,
  output logic                 take,
  output logic [31:0]          start_out,
  output logic [15:0]          count_out
);

  logic                 valid;
  logic [KEY_WIDTH-1:0] key_store;
  logic [31:0]          start;
  logic [15:0]          count;

  logic valid_eff, match, hit_here, free_here, ins;

  always_comb begin
    valid_eff = valid & ~(op.prune & expired(op.now, start, op.win));
    match     = valid_eff & (key_store == key);
    hit_here  = op.lookup & match & ~chain_in.hit;
    free_here = op.lookup & ~valid_eff & ~chain_in.free;
    ins       = free_here & ~global_hit;
    take      = hit_here | ins;
    chain_out.hit  = chain_in.hit | match;
    chain_out.free = chain_in.free | ~valid_eff;
  end

  assign start_out = start;
  assign count_out = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_eff | ins;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      key_store <= key;
      start     <= op.now;
      count     <= '0;
    end else if (sel) begin
      if (op.restart) begin
        start <= op.now;
      end
      count <= (op.restart ? 16'd0 : count) + {15'd0, op.incr};
    end
  end

endmodule

### design/kwfrl_table.sv
// A row of entry cells linked by the first-hit and first-free chain.
module kwfrl_table import kwfrl_pkg::*; #(
  parameter int ENTRIES   = DEF_SOURCE_ENTRIES,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_op_t             op,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [ENTRIES-1:0]   sel,
  output logic [ENTRIES-1:0]   take,
  output logic                 full,
  output logic [31:0]          rd_start,
  output logic [15:0]          rd_count
);

  chain_t              chain [ENTRIES+1];
  logic [31:0]         starts [ENTRIES];
  logic [15:0]         counts [ENTRIES];
  logic                global_hit;

  assign chain[0]   = '0;
  assign global_hit = chain[ENTRIES].hit;
  assign full       = op.lookup & ~chain[ENTRIES].hit & ~chain[ENTRIES].free;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kwfrl_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .key        (key),
      .global_hit (global_hit),
      .sel        (sel[i]),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .take       (take[i]),
      .start_out  (starts[i]),
      .count_out  (counts[i])
    );
  end

  // sel has at most one bit set, so an OR of masked entries reads the selected one
  always_comb begin
    rd_start = '0;
    rd_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_start = rd_start | (sel[i] ? starts[i] : 32'd0);
      rd_count = rd_count | (sel[i] ? counts[i] : 16'd0);
    end
  end

endmodule

### design/keyed_fixed_window_rate_limiter.sv
// Keyed fixed-window rate limiter top level.
// Requests enter on s_tvalid/s_tready/s_tdata (208 bits: time, source key, source
// length, address key, address valid, amount, reserve, payout and audit flags).
// One status item leaves per request on m_tvalid/m_tready/m_tdata.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block does not enforce it. A request is
// handled in up to five steps: source prune and lookup (address prune and budget
// expiry alongside), source window check, address lookup, address window and
// budget check with charge, then the result register. Early rejects and a full
// source table go from the first step straight to the result register, and a
// source over its limit after the source window check; s_tready returns in the
// cycle m_tvalid is set. Each table is a row of cells linked by a priority chain
// that picks the first matching and the first free entry combinationally.
// One request is in flight at a time.
// Reset (rst, synchronous) clears all entry valid bits, the budget window and
// restores the register defaults; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register; the next
// request is still accepted and worked on, and holds in its last step until the
// output register frees.
module keyed_fixed_window_rate_limiter import kwfrl_pkg::*; #(
  parameter int SOURCE_ENTRIES   = DEF_SOURCE_ENTRIES,
  parameter int DEST_ENTRIES     = DEF_DEST_ENTRIES,
  parameter int KEY_WIDTH        = DEF_KEY_WIDTH,
  parameter int MAX_SOURCE_BYTES = DEF_MAX_SOURCE_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // arrival_time, src_key, source_length, dest_key, dest_valid, amount,
  // reserve_ok, payout_ok, audit_ok, zero fill
  input  logic [IN_DATA_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status, payout_failed, quota_taken, zero fill
  output logic [OUT_DATA_W-1:0]  m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRC, S_SRC2, S_DST, S_DST2, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic        enabled;
  logic [31:0] pay_amount, source_window, dest_window, global_window, global_budget;
  logic [15:0] source_limit, address_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b1;
      pay_amount     <= 32'd1;
      source_window  <= 32'd86400;
      source_limit   <= 16'd1;
      dest_window    <= 32'd86400;
      address_limit  <= 16'd1;
      global_window  <= 32'd3600;
      global_budget  <= 32'd100;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_ENABLED:        if (!cfg_data[0]) enabled <= 1'b0;
        REG_PAY_AMOUNT:     pay_amount     <= cfg_data;
        REG_SOURCE_WINDOW:  source_window  <= cfg_data;
        REG_SOURCE_LIMIT:   source_limit   <= cfg_data[15:0];
        REG_DEST_WINDOW:    dest_window    <= cfg_data;
        REG_ADDRESS_LIMIT:  address_limit  <= cfg_data[15:0];
        REG_GLOBAL_WINDOW:  global_window  <= cfg_data;
        REG_GLOBAL_BUDGET:  global_budget  <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched request
  logic [31:0]          now;
  logic [KEY_WIDTH-1:0] skey, dkey;
  logic [7:0]           slen;
  logic                 dvalid, reserve_ok, payout_ok, audit_ok;
  logic [31:0]          amount;

  // budget state
  logic [31:0] budget_start, budget_spent;

  // tables
  cell_op_t                  src_op, dst_op;
  logic [SOURCE_ENTRIES-1:0] src_sel, src_take;
  logic [DEST_ENTRIES-1:0]   dst_sel, dst_take;
  logic                      src_full, dst_full;
  logic [31:0]               src_rd_start, dst_rd_start;
  logic [15:0]               src_rd_count, dst_rd_count;

  kwfrl_table #(.ENTRIES(SOURCE_ENTRIES), .KEY_WIDTH(KEY_WIDTH)) u_src (
    .clk(clk), .rst(rst), .op(src_op), .key(skey), .sel(src_sel), .take(src_take),
    .full(src_full), .rd_start(src_rd_start), .rd_count(src_rd_count)
  );

  kwfrl_table #(.ENTRIES(DEST_ENTRIES), .KEY_WIDTH(KEY_WIDTH)) u_dst (
    .clk(clk), .rst(rst), .op(dst_op), .key(dkey), .sel(dst_sel), .take(dst_take),
    .full(dst_full), .rd_start(dst_rd_start), .rd_count(dst_rd_count)
  );

  // per-step decisions
  logic        early_reject;
  status_t     early_status;
  logic        src_stale, dst_stale, bud_stale;
  logic [15:0] src_cnt_eff, dst_cnt_eff;
  logic [31:0] bud_start_eff, bud_spent_eff;
  logic [32:0] bud_sum;
  logic        dst_pass;

  always_comb begin
    early_reject = 1'b1;
    early_status = ST_PAID;
    if (!enabled) begin
      early_status = ST_DISABLED;
    end else if (slen == 8'd0 || {24'd0, slen} > 32'(MAX_SOURCE_BYTES) ||
                 amount == 32'd0 || amount != pay_amount) begin
      early_status = ST_INVALID;
    end else if (!dvalid) begin
      early_status = ST_BAD_ADDRESS;
    end else begin
      early_reject = 1'b0;
    end

    src_stale   = stale(now, src_rd_start, source_window);
    src_cnt_eff = src_stale ? 16'd0 : src_rd_count;
    dst_stale   = stale(now, dst_rd_start, dest_window);
    dst_cnt_eff = dst_stale ? 16'd0 : dst_rd_count;

    bud_stale     = stale(now, budget_start, global_window);
    bud_start_eff = bud_stale ? now : budget_start;
    bud_spent_eff = bud_stale ? 32'd0 : budget_spent;
    bud_sum       = {1'b0, bud_spent_eff} + {1'b0, amount};
    dst_pass      = (dst_cnt_eff < address_limit) && (bud_sum <= {1'b0, global_budget});

    src_op = '{prune: 1'b0, lookup: 1'b0, restart: 1'b0, incr: 1'b0,
               now: now, win: source_window};
    dst_op = '{prune: 1'b0, lookup: 1'b0, restart: 1'b0, incr: 1'b0,
               now: now, win: dest_window};
    unique case (state)
      S_SRC: begin
        src_op.prune  = ~early_reject;
        src_op.lookup = ~early_reject;
        dst_op.prune  = ~early_reject;
      end
      S_SRC2: src_op.restart = src_stale;
      S_DST: begin
        dst_op.prune  = 1'b1;
        dst_op.lookup = 1'b1;
      end
      S_DST2: begin
        dst_op.restart = dst_stale;
        dst_op.incr    = dst_pass & reserve_ok;
        src_op.incr    = dst_pass & reserve_ok;
      end
      default: ;
    endcase
  end

  status_t res_status;
  logic    res_pfail, res_taken;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      budget_start <= '0;
      budget_spent <= '0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_SRC;
          end
        end
        S_SRC: begin
          if (early_reject) begin
            state <= S_DONE;
          end else begin
            if (expired(now, budget_start, global_window)) begin
              budget_start <= '0;
              budget_spent <= '0;
            end
            state <= src_full ? S_DONE : S_SRC2;
          end
        end
        S_SRC2: state <= (src_cnt_eff >= source_limit) ? S_DONE : S_DST;
        S_DST:  state <= dst_full ? S_DONE : S_DST2;
        S_DST2: begin
          if (dst_cnt_eff < address_limit) begin
            budget_start <= bud_start_eff;
            budget_spent <= (dst_pass && reserve_ok) ? bud_sum[31:0] : bud_spent_eff;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      now        <= s_tdata[31:0];
      skey       <= s_tdata[32 +: KEY_WIDTH];
      slen       <= s_tdata[103:96];
      dkey       <= s_tdata[104 +: KEY_WIDTH];
      dvalid     <= s_tdata[168];
      amount     <= s_tdata[200:169];
      reserve_ok <= s_tdata[201];
      payout_ok  <= s_tdata[202];
      audit_ok   <= s_tdata[203];
      res_pfail  <= 1'b0;
      res_taken  <= 1'b0;
    end
    if (state == S_SRC) begin
      src_sel    <= src_take;
      res_status <= early_reject ? early_status : ST_RATE_LIMITED;
    end
    if (state == S_DST) begin
      dst_sel <= dst_take;
    end
    if (state == S_DST2 && dst_pass) begin
      if (!reserve_ok) begin
        res_status <= ST_FAILED;
      end else begin
        res_taken  <= 1'b1;
        res_pfail  <= ~payout_ok;
        res_status <= (payout_ok && audit_ok) ? ST_PAID : ST_FAILED;
      end
    end
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'd0, res_taken, res_pfail, res_status};
    end
  end

endmodule

### design/kwfrl_checker.sv
// Port-level checker for the rate limiter, bound to the top level.
`include "keyed_fixed_window_rate_limiter_macros.svh"

module kwfrl_checker import kwfrl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  `KWFRL_ASSERT_IMPLY(a_status_range, m_tvalid, m_tdata[2:0] <= ST_FAILED)
  `KWFRL_ASSERT_IMPLY(a_taken_status, m_tvalid && m_tdata[4],
                      m_tdata[2:0] == ST_PAID || m_tdata[2:0] == ST_FAILED)
  `KWFRL_ASSERT_IMPLY(a_pfail_taken, m_tvalid && m_tdata[3],
                      m_tdata[4] && m_tdata[2:0] == ST_FAILED)
  `KWFRL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind keyed_fixed_window_rate_limiter kwfrl_checker u_kwfrl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### verif/tb.sv
// Self-checking testbench for the keyed fixed-window rate limiter.
module tb;
  import kwfrl_pkg::*;

  localparam int NSLOT      = 16;
  localparam int STALL_MAX  = 5000;
  localparam int DRAIN_WAIT = 12;

  typedef struct {
    logic [31:0] now;
    logic [63:0] skey;
    logic [7:0]  slen;
    logic [63:0] dkey;
    logic        dvalid;
    logic [31:0] amount;
    logic        reserve;
    logic        payout;
    logic        audit;
  } request_t;

  typedef struct {
    status_t status;
    logic    pfail;
    logic    taken;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keyed_fixed_window_rate_limiter DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #6 clk = ~clk;

  // predictor copy of registers and tables (table 0 = source, 1 = address)
  logic        svc_on;
  logic [31:0] pay_amt, src_win, addr_win, glob_win, glob_budget;
  logic [15:0] src_lim, addr_lim;
  logic        slot_used [2][NSLOT];
  logic [63:0] slot_key  [2][NSLOT];
  logic [31:0] slot_t0   [2][NSLOT];
  logic [15:0] slot_cnt  [2][NSLOT];
  logic [31:0] spend_t0, spend_sum;

  request_t pending [$];
  verdict_t awaited [$];
  request_t cur_req;
  bit took = 0;
  bit errors = 0;
  bit finished = 0;
  int idle_cycles = 0;

  function automatic void queue_req(request_t r);
    pending.insert(pending.size(), r);
  endfunction

  function automatic bit past_window(logic [31:0] now, logic [31:0] t0, logic [31:0] w);
    return now >= t0 && (now - t0) >= w;
  endfunction

  function automatic bit off_window(logic [31:0] now, logic [31:0] t0, logic [31:0] w);
    return now < t0 || (now - t0) >= w;
  endfunction

  function automatic void drop_old(int t, logic [31:0] w, logic [31:0] now);
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[t][i] && past_window(now, slot_t0[t][i], w)) slot_used[t][i] = 0;
  endfunction

  // returns slot index, -1 when the table is full
  function automatic int claim_slot(int t, logic [31:0] w, logic [31:0] now,
                                    logic [63:0] key);
    int hit;
    int spare;
    hit = -1;
    spare = -1;
    drop_old(t, w, now);
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_used[t][i]) begin
        if (hit < 0 && slot_key[t][i] == key) hit = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (hit >= 0) return hit;
    if (spare < 0) return -1;
    slot_used[t][spare] = 1;
    slot_key[t][spare] = key;
    slot_t0[t][spare] = now;
    slot_cnt[t][spare] = 0;
    return spare;
  endfunction

  function automatic verdict_t judge_request(request_t r);
    verdict_t v;
    int s;
    int d;
    v = '{ST_PAID, 1'b0, 1'b0};
    if (!svc_on) return '{ST_DISABLED, 1'b0, 1'b0};
    if (r.slen == 0 || r.amount == 0 || r.amount != pay_amt)
      return '{ST_INVALID, 1'b0, 1'b0};
    if (!r.dvalid) return '{ST_BAD_ADDRESS, 1'b0, 1'b0};
    s = claim_slot(0, src_win, r.now, r.skey);
    drop_old(1, addr_win, r.now);
    if (past_window(r.now, spend_t0, glob_win)) begin
      spend_t0 = 0;
      spend_sum = 0;
    end
    if (s < 0) return '{ST_RATE_LIMITED, 1'b0, 1'b0};
    if (off_window(r.now, slot_t0[0][s], src_win)) begin
      slot_t0[0][s] = r.now;
      slot_cnt[0][s] = 0;
    end
    if (slot_cnt[0][s] >= src_lim) return '{ST_RATE_LIMITED, 1'b0, 1'b0};
    d = claim_slot(1, addr_win, r.now, r.dkey);
    if (d < 0) return '{ST_RATE_LIMITED, 1'b0, 1'b0};
    if (off_window(r.now, slot_t0[1][d], addr_win)) begin
      slot_t0[1][d] = r.now;
      slot_cnt[1][d] = 0;
    end
    if (slot_cnt[1][d] >= addr_lim) return '{ST_RATE_LIMITED, 1'b0, 1'b0};
    if (off_window(r.now, spend_t0, glob_win)) begin
      spend_t0 = r.now;
      spend_sum = 0;
    end
    if ({32'd0, spend_sum} + {32'd0, r.amount} > {32'd0, glob_budget})
      return '{ST_RATE_LIMITED, 1'b0, 1'b0};
    if (!r.reserve) return '{ST_FAILED, 1'b0, 1'b0};
    slot_cnt[0][s] = slot_cnt[0][s] + 1;
    slot_cnt[1][d] = slot_cnt[1][d] + 1;
    spend_sum = spend_sum + r.amount;
    v.taken = 1;
    if (!r.payout) begin
      v.status = ST_FAILED;
      v.pfail = 1;
    end else if (!r.audit) begin
      v.status = ST_FAILED;
    end
    return v;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_request(request_t r);
    return {4'd0, r.audit, r.payout, r.reserve, r.amount, r.dvalid, r.dkey, r.slen,
            r.skey, r.now};
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || took)) begin
      took = 0;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid = 0;
      end else if (pending.size() > 0) begin
        cur_req = pending.pop_front();
        s_tdata = pack_request(cur_req);
        s_tvalid = 1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        s_tvalid = 0;
      end
    end
  end

  // receiver: stall mode picked at random from four modes
  int rmode = 0;
  int rtick = 0;
  always @(negedge clk) begin
    rtick++;
    if (rtick % 150 == 0) rmode = $urandom_range(0, 3);
    case (rmode)
      0: m_tready = 1;
      1: m_tready = 1'($urandom_range(0, 1));
      2: m_tready = ($urandom_range(0, 3) == 0);
      default: m_tready = ((rtick / 8) % 2 == 0);
    endcase
  end

  // accept, predict and check on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        awaited.insert(awaited.size(), judge_request(cur_req));
        took = 1;
      end
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors = 1;
        end else begin
          verdict_t e;
          e = awaited.pop_front();
          if (m_tdata[2:0] !== e.status || m_tdata[3] !== e.pfail ||
              m_tdata[4] !== e.taken || m_tdata[7:5] !== 3'd0)
            begin
            $display("%0t: mismatch expected status=%0d pfail=%0b taken=%0b, got %h",
                     $time, e.status, e.pfail, e.taken, m_tdata);
            errors = 1;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    while (!finished && idle_cycles < STALL_MAX) @(posedge clk);
    if (!finished) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending.size() > 0 || s_tvalid || awaited.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_ENABLED:        if (!val[0]) svc_on = 0;
      REG_PAY_AMOUNT:     pay_amt = val;
      REG_SOURCE_WINDOW:  src_win = val;
      REG_SOURCE_LIMIT:   src_lim = val[15:0];
      REG_DEST_WINDOW:    addr_win = val;
      REG_ADDRESS_LIMIT:  addr_lim = val[15:0];
      REG_GLOBAL_WINDOW:  glob_win = val;
      default:            glob_budget = val;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic request_t good_req(logic [31:0] now, logic [63:0] sk,
                                        logic [63:0] dk);
    return '{now, sk, 8'd1, dk, 1'b1, pay_amt, 1'b1, 1'b1, 1'b1};
  endfunction

  logic [63:0] src_pool [24];
  logic [63:0] dst_pool [24];
  int pool_n;
  logic [31:0] clock_s;
  int tstep;

  function automatic request_t random_req();
    request_t r;
    r.now = clock_s;
    clock_s = clock_s + $urandom_range(0, tstep);
    if ($urandom_range(0, 39) == 0) clock_s = clock_s - $urandom_range(0, 3 * tstep);
    if ($urandom_range(0, 99) == 0) r.now = $urandom;
    r.skey = src_pool[$urandom_range(0, pool_n - 1)];
    r.dkey = dst_pool[$urandom_range(0, pool_n - 1)];
    r.slen = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    r.dvalid = ($urandom_range(0, 19) != 0);
    r.amount = pay_amt;
    if ($urandom_range(0, 19) == 0) r.amount = $urandom;
    else if ($urandom_range(0, 39) == 0) r.amount = 0;
    r.reserve = ($urandom_range(0, 11) != 0);
    r.payout = ($urandom_range(0, 9) != 0);
    r.audit = ($urandom_range(0, 9) != 0);
    return r;
  endfunction

  initial begin
    logic [63:0] bud;
    svc_on = 1; pay_amt = 1; src_win = 86400; src_lim = 1; addr_win = 86400;
    addr_lim = 1; glob_win = 3600; glob_budget = 100;
    spend_t0 = 0; spend_sum = 0;
    for (int t = 0; t < 2; t++)
      for (int i = 0; i < NSLOT; i++) begin
        slot_used[t][i] = 0; slot_key[t][i] = 0; slot_t0[t][i] = 0; slot_cnt[t][i] = 0;
      end
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed part at reset settings
    queue_req(good_req(100, 64'h1, 64'h2));
    queue_req(good_req(101, 64'h1, 64'h3));                      // source over limit
    queue_req('{102, 64'h5, 8'd0, 64'h6, 1'b1, 32'd1, 1'b1, 1'b1, 1'b1});
    queue_req('{103, 64'h5, 8'd255, 64'h6, 1'b1, 32'd0, 1'b1, 1'b1, 1'b1});
    queue_req('{104, 64'h5, 8'd255, 64'h6, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1});
    queue_req('{105, 64'h5, 8'd255, 64'h6, 1'b0, 32'd1, 1'b1, 1'b1, 1'b1});
    queue_req('{106, '1, 8'd255, '1, 1'b1, 32'd1, 1'b1, 1'b1, 1'b1});
    queue_req('{107, 64'h7, 8'd9, 64'h8, 1'b1, 32'd1, 1'b0, 1'b1, 1'b1});
    queue_req('{108, 64'h7, 8'd9, 64'h8, 1'b1, 32'd1, 1'b1, 1'b0, 1'b1});
    queue_req('{109, 64'h9, 8'd9, 64'hA, 1'b1, 32'd1, 1'b1, 1'b1, 1'b0});
    queue_req(good_req(50, 64'h1, 64'hB));                       // time going backwards
    queue_req(good_req(32'hFFFFFFFF, 64'hC, 64'hD));
    queue_req(good_req(32'hFFFFFFFF, 64'h1, 64'hE));             // window passed
    for (int i = 0; i < 5; i++) queue_req(good_req(200, 64'h20 + i, 64'h40 + i));
    wait_drained();

    // small tables fill up; budget runs out
    write_reg(REG_ENABLED, 32'd1);                               // no effect
    for (int p = 0; p < 6; p++) begin
      pay_amt = (p == 2) ? 32'hFFFFFFFF : 32'($urandom_range(1, 5));
      write_reg(REG_PAY_AMOUNT, pay_amt);
      write_reg(REG_SOURCE_WINDOW, (p == 3) ? 32'hFFFFFFFF : $urandom_range(1, 60));
      write_reg(REG_SOURCE_LIMIT, (p == 4) ? 32'hFFFF : $urandom_range(1, 3));
      write_reg(REG_DEST_WINDOW, (p == 4) ? 32'hFFFFFFFF : $urandom_range(1, 60));
      write_reg(REG_ADDRESS_LIMIT, (p == 3) ? 32'hFFFF : $urandom_range(1, 3));
      write_reg(REG_GLOBAL_WINDOW, (p == 5) ? 32'hFFFFFFFF :
                (p == 1 ? 32'd1 : $urandom_range(5, 100)));
      bud = 64'(pay_amt) * $urandom_range(2, 20);
      write_reg(REG_GLOBAL_BUDGET, (p == 5 || bud > 64'hFFFFFFFF) ? 32'hFFFFFFFF : bud[31:0]);
      for (int i = 0; i < 24; i++) begin
        src_pool[i] = {$urandom, $urandom};
        dst_pool[i] = {$urandom, $urandom};
      end
      pool_n = $urandom_range(6, 24);
      tstep = $urandom_range(1, 8);
      clock_s = (p == 0) ? 32'hFFFFFF00 : $urandom;
      for (int i = 0; i < 200; i++) queue_req(random_req());
      wait_drained();
    end

    write_reg(REG_ENABLED, 32'd0);
    for (int i = 0; i < 20; i++) queue_req(random_req());
    wait_drained();

    finished = 1;
    if (!errors) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
